[rtl/llca_pkg.sv]
// ----------------------------------------------------------------------------
// llca_pkg
// Shared word types and fixed field widths of the least-loaded chunk assigner.
// ----------------------------------------------------------------------------
package llca_pkg;

  localparam int unsigned CHUNK_W = 16;
  localparam int unsigned MASK_W  = 8;
  localparam int unsigned PEER_W  = 3;
  localparam int unsigned LOAD_W  = 16;
  localparam int unsigned CFG_W   = 4;

  localparam logic [CFG_W-1:0] ACTIVE_PEERS_RESET = 4'd8;

  // One chunk descriptor.
  typedef struct packed {
    logic [CHUNK_W-1:0] chunk_index;
    logic               already_have;
    logic [MASK_W-1:0]  holder_mask;
    logic               first_of_file;
  } in_word_t;

  // One assignment result.
  typedef struct packed {
    logic [CHUNK_W-1:0] chunk_echo;
    logic               assigned;
    logic [PEER_W-1:0]  chosen_peer;
    logic [LOAD_W-1:0]  peer_load;
  } out_word_t;

endpackage

[rtl/llca_select.sv]
// ----------------------------------------------------------------------------
// llca_select
// Masked minimum over the peer counters; ties go to the lower peer index.
// ----------------------------------------------------------------------------
module llca_select #(
  parameter int unsigned MAX_PEERS   = 8,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic [MAX_PEERS-1:0]                     eligible_i,
  input  logic [MAX_PEERS-1:0][COUNT_WIDTH-1:0]    counts_i,
  output logic                                     found_o,
  output logic [$clog2(MAX_PEERS)-1:0]             best_o
);

  localparam int unsigned PIDX_W = $clog2(MAX_PEERS);
  localparam int unsigned LEAVES = 1 << PIDX_W;

  logic [2*LEAVES-1:0]                   node_v;
  logic [2*LEAVES-1:0][COUNT_WIDTH-1:0]  node_c;
  logic [2*LEAVES-1:0][PIDX_W-1:0]       node_i;

  // Tournament tree: leaves at LEAVES+p, root at 1; right wins only if
  // strictly smaller, so the lower index keeps ties.
  always_comb begin
    node_v = '0;
    node_c = '0;
    node_i = '0;
    for (int p = 0; p < LEAVES; p++) begin
      node_i[LEAVES+p] = PIDX_W'(p);
      if (p < MAX_PEERS) begin
        node_v[LEAVES+p] = eligible_i[p];
        node_c[LEAVES+p] = counts_i[p];
      end
    end
    for (int k = LEAVES - 1; k >= 1; k--) begin
      if (node_v[2*k+1] && (!node_v[2*k] || (node_c[2*k+1] < node_c[2*k]))) begin
        node_v[k] = 1'b1;
        node_c[k] = node_c[2*k+1];
        node_i[k] = node_i[2*k+1];
      end else begin
        node_v[k] = node_v[2*k];
        node_c[k] = node_c[2*k];
        node_i[k] = node_i[2*k];
      end
    end
  end

  assign found_o = node_v[1];
  assign best_o  = node_i[1];

endmodule

[rtl/llca_counts.sv]
// ----------------------------------------------------------------------------
// llca_counts
// Per-peer assignment counters with file-start clear and saturating increment.
// ----------------------------------------------------------------------------
module llca_counts #(
  parameter int unsigned MAX_PEERS   = 8,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  fire_i,
  input  logic                                  clear_i,
  input  logic                                  found_i,
  input  logic [$clog2(MAX_PEERS)-1:0]          best_i,
  output logic [MAX_PEERS-1:0][COUNT_WIDTH-1:0] view_o,
  output logic [COUNT_WIDTH-1:0]                load_o
);

  localparam int unsigned PIDX_W = $clog2(MAX_PEERS);

  logic [MAX_PEERS-1:0][COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [COUNT_WIDTH-1:0]                base;

  // Counters as the current word sees them: zero when it opens a new file.
  assign view_o = clear_i ? '0 : cnt_q;

  always_comb begin
    base = '0;
    for (int p = 0; p < MAX_PEERS; p++) begin
      if (best_i == PIDX_W'(p)) begin
        base = view_o[p];
      end
    end
  end

  // Hold at the maximum instead of wrapping.
  assign load_o = (base == '1) ? base : base + COUNT_WIDTH'(1);

  always_comb begin
    cnt_d = cnt_q;
    if (fire_i) begin
      cnt_d = view_o;
      for (int p = 0; p < MAX_PEERS; p++) begin
        if (found_i && (best_i == PIDX_W'(p))) begin
          cnt_d[p] = load_o;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

[rtl/least_loaded_chunk_assigner_top.sv]
// ----------------------------------------------------------------------------
// least_loaded_chunk_assigner_top
// Assigns each missing chunk to the least-loaded active holder peer.
// ----------------------------------------------------------------------------
// Each input word describes one chunk and yields exactly one result word. The
// block takes one word per clock cycle when the output side is not stalled,
// and delivers its result through the input register, then the result
// register. The rate rests on the counter loop: the masked minimum over the
// peer counters, the saturating increment and the counter write-back all
// happen in the single cycle in which a word moves from the input register
// into the result register, so the following word already sees the updated
// counts. A word with first_of_file set clears all counters before it is
// handled. A chunk that is held locally, or that no active peer holds, is
// answered with assigned low, chosen_peer and peer_load zero, and leaves the
// counters alone. The active_peers register (reset value 8) is written
// through the configuration channel, which is always ready; write it only
// while no word is in flight. Mask bits at or above active_peers, and at or
// above MAX_PEERS, are ignored.
module least_loaded_chunk_assigner_top
  import llca_pkg::*;
#(
  parameter int unsigned MAX_PEERS   = 8,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input word channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_word_t         in_word_i,
  // result word channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_word_t        out_word_o,
  // configuration write channel
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int unsigned PIDX_W = $clog2(MAX_PEERS);

  logic [CFG_W-1:0] active_q;

  logic      s1_valid_q;
  in_word_t  s1_word_q;
  logic      out_valid_q;
  out_word_t out_word_q, out_word_d;

  logic move;
  logic in_fire;

  logic [MAX_PEERS-1:0]                  eligible;
  logic [MAX_PEERS-1:0][COUNT_WIDTH-1:0] view;
  logic                                  found;
  logic [PIDX_W-1:0]                     best;
  logic [COUNT_WIDTH-1:0]                load;

  // Advance the held word when the result register is empty or being taken.
  assign move       = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !move;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_PEERS_RESET;
    end else if (cfg_valid_i) begin
      active_q <= cfg_data_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_word_q <= in_word_i;
    end
  end

  // A peer competes if it is active, holds the chunk, and the chunk is missing.
  always_comb begin
    eligible = '0;
    for (int p = 0; p < MAX_PEERS; p++) begin
      if ((p < MASK_W) && (p < int'(active_q))) begin
        eligible[p] = !s1_word_q.already_have && s1_word_q.holder_mask[p % MASK_W];
      end
    end
  end

  llca_select #(
    .MAX_PEERS  (MAX_PEERS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_select (
    .eligible_i(eligible),
    .counts_i  (view),
    .found_o   (found),
    .best_o    (best)
  );

  llca_counts #(
    .MAX_PEERS  (MAX_PEERS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_counts (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (move),
    .clear_i(s1_word_q.first_of_file),
    .found_i(found),
    .best_i (best),
    .view_o (view),
    .load_o (load)
  );

  always_comb begin
    out_word_d.chunk_echo  = s1_word_q.chunk_index;
    out_word_d.assigned    = found;
    out_word_d.chosen_peer = found ? PEER_W'(best) : '0;
    out_word_d.peer_load   = found ? LOAD_W'(load) : '0;
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // The input side stalls only while a word is held and cannot advance.
  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked word");

  // An empty answer carries no peer and no load.
  a_empty_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.assigned) |->
      (out_word_o.chosen_peer == '0 && out_word_o.peer_load == '0))
    else $error("unassigned result carries peer or load");

  // A chosen peer is always below the active peer count.
  a_peer_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && found) |-> (int'(best) < int'(active_q)))
    else $error("inactive peer chosen");

  // A word that advances with a held chunk never assigns.
  a_have_no_assign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && s1_word_q.already_have) |=> (out_valid_o && !out_word_o.assigned))
    else $error("locally held chunk was assigned");

endmodule
